// ----- rtl/bfa_pkg.sv -----
// Package: shared constants, types and state encoding of the frame allocator.
package bfa_pkg;

   localparam int unsigned FRAMES_DEF     = 65536;
   localparam int unsigned PAGE_BYTES_DEF = 4096;
   localparam int unsigned WORD_BITS      = 64;
   localparam int unsigned WORD_SHIFT     = 6;

   localparam logic FUNC_RESERVE = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_ZERO      = 3'd1;
   localparam logic [2:0] ST_UNALIGNED = 3'd2;
   localparam logic [2:0] ST_RANGE     = 3'd3;
   localparam logic [2:0] ST_NOFIT     = 3'd4;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SCAN_RD,
      S_SCAN,
      S_MARK_RD,
      S_MARK,
      S_RESULT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear_step;
      logic load;
      logic scan_read;
      logic scan_step;
      logic mark_init;
      logic mark_read;
      logic mark_step;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_done;
      logic fail;
      logic is_release;
      logic scan_found;
      logic scan_end;
      logic mark_done;
   } stat_type;

endpackage

// ----- rtl/bfa_ram.sv -----
// Generic single-port RAM with registered read.
module bfa_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bfa_ctrl.sv -----
// Controller: sequences clearing, checking, scanning, marking and the response.
module bfa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  bfa_pkg::stat_type stat,
   output bfa_pkg::cmd_type  cmd
);

   bfa_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfa_pkg::S_CLEAR:   if (stat.clear_done) state_in = bfa_pkg::S_IDLE;
         bfa_pkg::S_IDLE:    if (req_valid) state_in = bfa_pkg::S_CHECK;
         bfa_pkg::S_CHECK: begin
            if (stat.fail) begin
               state_in = bfa_pkg::S_RESULT;
            end else if (stat.is_release) begin
               state_in = bfa_pkg::S_MARK_RD;
            end else begin
               state_in = bfa_pkg::S_SCAN_RD;
            end
         end
         bfa_pkg::S_SCAN_RD: state_in = bfa_pkg::S_SCAN;
         bfa_pkg::S_SCAN: begin
            if (stat.scan_found) begin
               state_in = bfa_pkg::S_MARK_RD;
            end else if (stat.scan_end) begin
               state_in = bfa_pkg::S_RESULT;
            end else begin
               state_in = bfa_pkg::S_SCAN_RD;
            end
         end
         bfa_pkg::S_MARK_RD: state_in = bfa_pkg::S_MARK;
         bfa_pkg::S_MARK: begin
            state_in = stat.mark_done ? bfa_pkg::S_RESULT : bfa_pkg::S_MARK_RD;
         end
         bfa_pkg::S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = bfa_pkg::S_IDLE;
         end
         default:            state_in = bfa_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.clear_step = (state_ff == bfa_pkg::S_CLEAR);
      cmd.load       = (state_ff == bfa_pkg::S_IDLE) && req_valid;
      cmd.scan_read  = (state_ff == bfa_pkg::S_SCAN_RD);
      cmd.scan_step  = (state_ff == bfa_pkg::S_SCAN);
      cmd.mark_init  = (state_ff == bfa_pkg::S_CHECK) ||
                       ((state_ff == bfa_pkg::S_SCAN) && stat.scan_found);
      cmd.mark_read  = (state_ff == bfa_pkg::S_MARK_RD);
      cmd.mark_step  = (state_ff == bfa_pkg::S_MARK);
      cmd.rsp_load   = (state_ff == bfa_pkg::S_RESULT) && (!rsp_valid_ff || !rsp_stall);
      req_stall      = (state_ff != bfa_pkg::S_IDLE);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfa_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/bfa_datapath.sv -----
// Datapath: bitmap memory, request checks, word-wise first-fit scan and run marking.
module bfa_datapath #(
   parameter int unsigned FRAMES     = bfa_pkg::FRAMES_DEF,
   parameter int unsigned PAGE_BYTES = bfa_pkg::PAGE_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  bfa_pkg::cmd_type  cmd,
   output bfa_pkg::stat_type stat,
   input  logic              req_func,
   input  logic [16:0]       req_frame_count,
   input  logic [31:0]       req_phys_addr,
   output logic [2:0]        rsp_status,
   output logic [31:0]       rsp_frame_addr
);

   localparam int unsigned WB     = bfa_pkg::WORD_BITS;
   localparam int unsigned WS     = bfa_pkg::WORD_SHIFT;
   localparam int unsigned WORDS  = (FRAMES + WB - 1) / WB;
   localparam int unsigned AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned FW     = $clog2(FRAMES) + 1;     // holds FRAMES itself
   localparam int unsigned PSH    = $clog2(PAGE_BYTES);
   localparam int unsigned CW     = 18;                      // run length / count
   localparam logic [FW-1:0] FRAMES_V = FW'(FRAMES);

   // Request registers
   logic              func_ff;
   logic [CW-1:0]     count_ff;
   logic [31:0]       addr_ff;
   // Scan / mark registers
   logic [FW-1:0]     pos_ff, pos_in;       // next frame to examine
   logic [CW-1:0]     run_ff, run_in;
   logic [FW-1:0]     first_ff, first_in;
   logic [CW-1:0]     left_ff, left_in;     // frames still to mark
   logic [2:0]        status_ff, status_in;
   logic [AW:0]       clr_ff;
   logic [2:0]        rsp_status_ff;
   logic [31:0]       rsp_addr_ff;

   // Memory port
   logic              wr_en;
   logic [AW-1:0]     mem_addr;
   logic [WB-1:0]     wr_data, rd_data;

   bfa_ram #(.WIDTH(WB), .DEPTH(1 << AW)) u_map (
      .clock  (clock),
      .wr_en  (wr_en),
      .addr   (mem_addr),
      .wr_data(wr_data),
      .rd_data(rd_data)
   );

   // Request checks
   logic [31:0]   start_frame;
   logic          range_bad;
   logic [2:0]    chk_status;
   assign start_frame = addr_ff >> PSH;
   always_comb begin
      range_bad = 1'b0;
      if (33'(start_frame) >= 33'(FRAMES)) begin
         range_bad = 1'b1;
      end else if (func_ff == bfa_pkg::FUNC_RELEASE &&
                   33'(count_ff) > 33'(FRAMES) - 33'(start_frame)) begin
         range_bad = 1'b1;
      end
      if (count_ff == '0) begin
         chk_status = bfa_pkg::ST_ZERO;
      end else if (addr_ff[PSH-1:0] != '0) begin
         chk_status = bfa_pkg::ST_UNALIGNED;
      end else if (range_bad) begin
         chk_status = bfa_pkg::ST_RANGE;
      end else begin
         chk_status = bfa_pkg::ST_OK;
      end
   end

   // Scan one word in parallel. Free bits from pos to the word end form a mask;
   // runs of 2**k free bits are built by doubling and combined along the binary
   // digits of the count, which marks every start of a fitting run inside the
   // word. A run carried in from earlier words needs one compare against the
   // free prefix of the word and always ends first.
   logic [WS-1:0]   bit_lo;
   logic [FW-1:0]   word_base;
   logic [WB-1:0]   free_vec;
   logic [WB-1:0]   lead_free;
   logic [WB-1:0]   span [WS+1];
   logic [WB-1:0]   fit_start;
   logic            lead_run;
   logic [WS-1:0]   win_start;
   logic            win_ok;
   logic [CW-1:0]   tail_free;
   logic [CW-1:0]   need;
   logic [CW-1:0]   avail;
   logic [WS-1:0]   carry_end;
   logic            carry_ok;
   logic [CW-1:0]   srun;
   logic            sfound;
   logic [FW-1:0]   sfirst;
   always_comb begin
      bit_lo    = pos_ff[WS-1:0];
      word_base = {pos_ff[FW-1:WS], {WS{1'b0}}};
      avail     = CW'(WB) - CW'(bit_lo);
      for (int b = 0; b < WB; b++) begin
         free_vec[b] = !rd_data[b] && (b >= int'(bit_lo)) &&
                       (word_base + FW'(b) < FRAMES_V);
      end
      lead_run = 1'b1;
      for (int b = 0; b < WB; b++) begin
         if (b >= int'(bit_lo)) begin
            lead_run = lead_run & free_vec[b];
         end
         lead_free[b] = lead_run;
      end
      span[0] = free_vec;
      for (int k = 0; k < WS; k++) begin
         span[k+1] = span[k] & (span[k] >> (1 << k));
      end
      fit_start = '1;
      for (int k = 0; k <= WS; k++) begin
         if (count_ff[k]) begin
            fit_start = fit_start & (span[k] >> (count_ff & CW'((1 << k) - 1)));
         end
      end
      win_ok    = (count_ff <= CW'(WB)) && (fit_start != '0);
      win_start = '0;
      for (int b = WB - 1; b >= 0; b--) begin
         if (fit_start[b]) begin
            win_start = WS'(b);
         end
      end
      tail_free = '0;
      for (int b = 0; b < WB; b++) begin
         if (!free_vec[b]) begin
            tail_free = CW'(WB - 1 - b);
         end
      end
      need      = count_ff - run_ff;
      carry_end = WS'(CW'(bit_lo) + need - 1'b1);
      carry_ok  = (need <= avail) && lead_free[carry_end];
      sfound    = carry_ok || win_ok;
      if (carry_ok) begin
         sfirst = word_base + FW'(carry_end) + 1'b1 - FW'(count_ff);
      end else begin
         sfirst = word_base + FW'(win_start);
      end
      srun = lead_free[WB-1] ? (run_ff + avail) : tail_free;
   end

   // Mark one word: bits from pos upward, at most left of them
   logic [WB-1:0] mask;
   logic [CW-1:0] nmark;
   always_comb begin
      mask  = '0;
      nmark = (left_ff < avail) ? left_ff : avail;
      for (int b = 0; b < WB; b++) begin
         if (b >= int'(bit_lo) && CW'(b - int'(bit_lo)) < left_ff) begin
            mask[b] = 1'b1;
         end
      end
   end

   always_comb begin
      wr_en    = 1'b0;
      wr_data  = '0;
      mem_addr = pos_ff[AW+WS-1:WS];
      if (cmd.clear_step) begin
         wr_en    = 1'b1;
         wr_data  = '1;
         mem_addr = clr_ff[AW-1:0];
      end else if (cmd.mark_step) begin
         wr_en   = 1'b1;
         wr_data = func_ff ? (rd_data & ~mask) : (rd_data | mask);
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      run_in    = run_ff;
      first_in  = first_ff;
      left_in   = left_ff;
      status_in = status_ff;
      if (cmd.load) begin
         run_in   = '0;
      end
      if (cmd.mark_init && !cmd.scan_step) begin
         status_in = chk_status;
         pos_in    = start_frame[FW-1:0];
         left_in   = count_ff;
         first_in  = start_frame[FW-1:0];
      end
      if (cmd.scan_step) begin
         run_in = srun;
         pos_in = word_base + FW'(WB);
         if (sfound) begin
            first_in = sfirst;
            pos_in   = sfirst;
            left_in  = count_ff;
         end else if (word_base + FW'(WB) >= FRAMES_V) begin
            status_in = bfa_pkg::ST_NOFIT;
         end
      end
      if (cmd.mark_step) begin
         left_in = left_ff - nmark;
         pos_in  = word_base + FW'(WB);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step && !clr_ff[AW]) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         count_ff <= CW'(req_frame_count);
         addr_ff  <= req_phys_addr;
      end
      pos_ff    <= pos_in;
      run_ff    <= run_in;
      first_ff  <= first_in;
      left_ff   <= left_in;
      status_ff <= status_in;
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_addr_ff   <= (status_ff == bfa_pkg::ST_OK && func_ff == bfa_pkg::FUNC_RESERVE)
                          ? 32'(64'(first_ff) << PSH) : 32'd0;
      end
   end

   assign stat.clear_done = (clr_ff[AW-1:0] == '1) || clr_ff[AW];
   assign stat.fail       = (chk_status != bfa_pkg::ST_OK);
   assign stat.is_release = (func_ff == bfa_pkg::FUNC_RELEASE);
   assign stat.scan_found = sfound;
   assign stat.scan_end   = (word_base + FW'(WB) >= FRAMES_V);
   assign stat.mark_done  = (left_ff == nmark);

   assign rsp_status     = rsp_status_ff;
   assign rsp_frame_addr = rsp_addr_ff;

endmodule

// ----- rtl/bitmap_frame_allocator.sv -----
// Top level of the bitmap page-frame allocator.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_func, req_frame_count, req_phys_addr
//  rsp      out        rsp_valid/rsp_stall   rsp_status, rsp_frame_addr
//
// Cycles: one request at a time. A request spends one cycle being taken, one
// being checked, two per 64-frame bitmap word scanned, two per word marked or
// released and one loading the response; the single-port bitmap RAM sets the pace.
// Reset: after reset a clearing pass writes every RAM word to all ones, one word
// a cycle (1024 cycles at the default map size), with req_stall high throughout.
// Stalls: the response register holds while rsp_stall is high; the next request
// is accepted once the response has been loaded.
module bitmap_frame_allocator #(
   parameter int unsigned FRAMES     = bfa_pkg::FRAMES_DEF,
   parameter int unsigned PAGE_BYTES = bfa_pkg::PAGE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [16:0] req_frame_count,
   input  logic [31:0] req_phys_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_frame_addr
);

   bfa_pkg::cmd_type  cmd;
   bfa_pkg::stat_type stat;

   // Sequence the request
   bfa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   // Hold the bitmap and do the word-wise work
   bfa_datapath #(.FRAMES(FRAMES), .PAGE_BYTES(PAGE_BYTES)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_func       (req_func),
      .req_frame_count(req_frame_count),
      .req_phys_addr  (req_phys_addr),
      .rsp_status     (rsp_status),
      .rsp_frame_addr (rsp_frame_addr)
   );

`ifndef ASSERT_OFF
   // A failed request never carries an address
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bfa_pkg::ST_OK |-> rsp_frame_addr == 32'd0)
      else $error("failed request returned an address");

   // No request is taken while a memory write is in flight
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_step || cmd.clear_step |-> req_stall)
      else $error("request taken during map update");

   // Returned address is page aligned
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_addr[$clog2(PAGE_BYTES)-1:0] == '0)
      else $error("unaligned address returned");
`endif

endmodule

// ----- tb/bitmap_frame_allocator_tb.sv -----
// Self-checking testbench for the bitmap page-frame allocator.
`timescale 1ns / 1ps

module bitmap_frame_allocator_tb;

   localparam int unsigned FRAMES     = bfa_pkg::FRAMES_DEF;
   localparam int unsigned PAGE_BYTES = bfa_pkg::PAGE_BYTES_DEF;
   localparam int unsigned RANDOM_REQUESTS = 1500;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] frame_addr;
   } reply_type;

   // One row of the directed table; a typed reply overrides the predictor.
   typedef struct {
      logic        func;
      logic [16:0] count;
      logic [31:0] addr;
      bit          typed;
      reply_type   want;
   } directed_row_type;

   typedef struct {
      int unsigned first;
      int unsigned count;
   } run_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = bfa_pkg::FUNC_RESERVE;
   logic [16:0] req_frame_count = '0;
   logic [31:0] req_phys_addr = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_frame_addr;

   // Predictor state: one used bit per frame, all used after reset.
   bit          frame_used [FRAMES];
   reply_type   pending_replies [$];
   run_type     live_runs [$];
   int unsigned failures = 0;
   bit          quiet = 1'b0;

   bitmap_frame_allocator #(.FRAMES(FRAMES), .PAGE_BYTES(PAGE_BYTES)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_frame_count(req_frame_count), .req_phys_addr(req_phys_addr),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_frame_addr(rsp_frame_addr)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Work out the reply to one request and apply it to the frame map.
   function automatic reply_type predict_frame_op(input logic func,
                                                  input logic [16:0] count,
                                                  input logic [31:0] addr);
      reply_type   r;
      int unsigned start;
      int unsigned run;
      int unsigned i;
      r.status     = bfa_pkg::ST_OK;
      r.frame_addr = '0;
      start        = addr / PAGE_BYTES;
      if (count == 0) begin
         r.status = bfa_pkg::ST_ZERO;
      end else if (addr % PAGE_BYTES != 0) begin
         r.status = bfa_pkg::ST_UNALIGNED;
      end else if (func == bfa_pkg::FUNC_RESERVE) begin
         if (start >= FRAMES) begin
            r.status = bfa_pkg::ST_RANGE;
         end else begin
            // First fit upward from the start frame, no wrap.
            run      = 0;
            r.status = bfa_pkg::ST_NOFIT;
            for (i = start; i < FRAMES; i++) begin
               if (frame_used[i]) begin
                  run = 0;
               end else begin
                  run++;
                  if (run == count) begin
                     r.status     = bfa_pkg::ST_OK;
                     r.frame_addr = (i + 1 - count) * PAGE_BYTES;
                     for (int unsigned j = i + 1 - count; j <= i; j++)
                        frame_used[j] = 1'b1;
                     break;
                  end
               end
            end
         end
      end else begin
         if (start >= FRAMES || count > FRAMES - start) begin
            r.status = bfa_pkg::ST_RANGE;
         end else begin
            for (i = start; i < start + count; i++)
               frame_used[i] = 1'b0;
         end
      end
      return r;
   endfunction

   // Latest prediction, read back to track runs that were granted.
   function automatic reply_type predict_status_peek();
      return pending_replies.size() != 0 ? pending_replies[$] : reply_type'('0);
   endfunction

   // Present one request, hold it until accepted, then queue its reply.
   task automatic issue_request(input logic func, input logic [16:0] count,
                                input logic [31:0] addr, input bit typed = 1'b0,
                                input reply_type want = '0);
      reply_type predicted;
      @(negedge clock);
      if (!quiet && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_func        <= func;
      req_frame_count <= count;
      req_phys_addr   <= addr;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = predict_frame_op(func, count, addr);
      pending_replies.push_back(typed ? want : predicted);
   endtask

   task automatic wait_drained();
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // Release one tracked run, picked at random.
   task automatic release_live_run();
      int unsigned k;
      run_type     r;
      k = $urandom_range(live_runs.size() - 1);
      r = live_runs[k];
      live_runs.delete(k);
      issue_request(bfa_pkg::FUNC_RELEASE, r.count[16:0], r.first * PAGE_BYTES);
   endtask

   // Stall the reply channel at random, except during the quiet stretch.
   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 15);
   end

   // Compare each accepted reply with the oldest prediction.
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected reply: status %0d addr %h", rsp_status, rsp_frame_addr);
            failures++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_frame_addr !== want.frame_addr) begin
               $error("frame_addr: expected %h, got %h", want.frame_addr, rsp_frame_addr);
               failures++;
            end
         end
      end
   end

   // Directed table: errors, extremes and simple fits from the all-used reset map.
   directed_row_type directed [] = '{
      '{bfa_pkg::FUNC_RESERVE, 17'd0,     32'h0000_0000, 1'b1, '{bfa_pkg::ST_ZERO, 32'h0}},
      '{bfa_pkg::FUNC_RELEASE, 17'd0,     32'h0000_0000, 1'b1, '{bfa_pkg::ST_ZERO, 32'h0}},
      '{bfa_pkg::FUNC_RESERVE, 17'd1,     32'h0000_0001, 1'b1,
        '{bfa_pkg::ST_UNALIGNED, 32'h0}},
      '{bfa_pkg::FUNC_RELEASE, 17'd1,     32'h0000_0FFF, 1'b1,
        '{bfa_pkg::ST_UNALIGNED, 32'h0}},
      '{bfa_pkg::FUNC_RESERVE, 17'h1FFFF, 32'hFFFF_FFFF, 1'b1,
        '{bfa_pkg::ST_UNALIGNED, 32'h0}},
      '{bfa_pkg::FUNC_RESERVE, 17'd1,     32'h1000_0000, 1'b1, '{bfa_pkg::ST_RANGE, 32'h0}},
      '{bfa_pkg::FUNC_RESERVE, 17'd1,     32'hFFFF_F000, 1'b1, '{bfa_pkg::ST_RANGE, 32'h0}},
      '{bfa_pkg::FUNC_RELEASE, 17'd1,     32'hFFFF_F000, 1'b1, '{bfa_pkg::ST_RANGE, 32'h0}},
      '{bfa_pkg::FUNC_RESERVE, 17'd1,     32'h0000_0000, 1'b1, '{bfa_pkg::ST_NOFIT, 32'h0}},
      '{bfa_pkg::FUNC_RELEASE, 17'd2,     32'h0FFF_F000, 1'b1, '{bfa_pkg::ST_RANGE, 32'h0}},
      '{bfa_pkg::FUNC_RELEASE, 17'd1,     32'h0FFF_F000, 1'b1, '{bfa_pkg::ST_OK,    32'h0}},
      '{bfa_pkg::FUNC_RESERVE, 17'd1,     32'h0FFF_F000, 1'b1,
        '{bfa_pkg::ST_OK, 32'h0FFF_F000}},
      '{bfa_pkg::FUNC_RELEASE, 17'd65536, 32'h0000_0000, 1'b1, '{bfa_pkg::ST_OK,    32'h0}},
      '{bfa_pkg::FUNC_RESERVE, 17'd65536, 32'h0000_0000, 1'b1, '{bfa_pkg::ST_OK,    32'h0}},
      '{bfa_pkg::FUNC_RELEASE, 17'h1FFFF, 32'h0000_0000, 1'b1, '{bfa_pkg::ST_RANGE, 32'h0}},
      '{bfa_pkg::FUNC_RELEASE, 17'd64,    32'h0004_0000, 1'b1, '{bfa_pkg::ST_OK,    32'h0}},
      '{bfa_pkg::FUNC_RESERVE, 17'd65,    32'h0000_0000, 1'b1, '{bfa_pkg::ST_NOFIT, 32'h0}},
      '{bfa_pkg::FUNC_RESERVE, 17'd64,    32'h0000_0000, 1'b1,
        '{bfa_pkg::ST_OK, 32'h0004_0000}},
      '{bfa_pkg::FUNC_RELEASE, 17'd3,     32'h0001_0000, 1'b0, '{bfa_pkg::ST_OK,    32'h0}},
      '{bfa_pkg::FUNC_RELEASE, 17'd3,     32'h0001_0000, 1'b0, '{bfa_pkg::ST_OK,    32'h0}},
      '{bfa_pkg::FUNC_RESERVE, 17'd2,     32'h0001_1000, 1'b0, '{bfa_pkg::ST_OK,    32'h0}},
      '{bfa_pkg::FUNC_RESERVE, 17'd2,     32'h0000_0000, 1'b0, '{bfa_pkg::ST_OK,    32'h0}},
      '{bfa_pkg::FUNC_RELEASE, 17'd1,     32'h0001_0000, 1'b0, '{bfa_pkg::ST_OK,    32'h0}}
   };

   initial begin
      int unsigned pick;
      run_type     r;
      reply_type   last;
      foreach (frame_used[i]) frame_used[i] = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         issue_request(directed[i].func, directed[i].count, directed[i].addr,
                       directed[i].typed, directed[i].want);
      // Hold off the sender until every reply is in.
      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();

      // Free a low working region so most reserves fit quickly.
      issue_request(bfa_pkg::FUNC_RELEASE, 17'd8192, 32'h0);

      for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
         quiet = (n >= 600 && n < 850);
         pick  = $urandom_range(99);
         if (n == 1000) begin
            @(negedge clock);
            req_valid <= 1'b0;
            wait_drained();
         end
         if (pick >= 45 && pick < 80 && live_runs.size() != 0) begin
            release_live_run();
         end else if (pick < 85) begin
            // Reserve: mostly small runs low in the map, now and then a huge one.
            r.count = (pick >= 80) ? $urandom_range(1, 65536) : $urandom_range(1, 16);
            issue_request(bfa_pkg::FUNC_RESERVE, r.count[16:0],
                          $urandom_range(0, (pick >= 80) ? 8191 : 2047) * PAGE_BYTES);
            last = predict_status_peek();
            if (last.status == bfa_pkg::ST_OK) begin
               r.first = last.frame_addr / PAGE_BYTES;
               live_runs.push_back(r);
            end
         end else if (pick < 92) begin
            // Zero count or a misaligned address, either operation.
            if ($urandom_range(1))
               issue_request(1'($urandom_range(1)), 17'd0, $urandom());
            else
               issue_request(1'($urandom_range(1)), 17'($urandom_range(1, 17'h1FFFF)),
                             $urandom() | $urandom_range(1, PAGE_BYTES - 1));
         end else begin
            // Noise across the whole field ranges, half of it page aligned.
            issue_request(1'($urandom_range(1)), 17'($urandom_range(0, 17'h1FFFF)),
                          $urandom_range(1) ? ($urandom() & ~(PAGE_BYTES - 1)) : $urandom());
         end
         if (live_runs.size() > 96) release_live_run();
      end
      @(negedge clock);
      req_valid <= 1'b0;
      quiet = 1'b0;

      wait_drained();
      repeat (200) @(posedge clock);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #400_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
